// ----- rtl/block_index_search_unit_defines.svh -----
// ---------------------------------------------------------------------------
// block_index_search_unit_defines - assertion macros
// Shared concurrent assertion forms for the block index search unit.
// ---------------------------------------------------------------------------
`ifndef BLOCK_INDEX_SEARCH_UNIT_DEFINES_SVH
`define BLOCK_INDEX_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define BIS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define BIS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bis_pkg.sv -----
// ---------------------------------------------------------------------------
// bis_pkg - block index search shared types
// Item codes, result codes, controller states and control/status bundles.
// ---------------------------------------------------------------------------
`default_nettype none

package bis_pkg;

  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int BLK_OUT_W  = 3;
  localparam int POS_OUT_W  = 4;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND = 2'd0,
    ST_MISS  = 2'd1,
    ST_DONE  = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_KEY,
    S_ELEM,
    S_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    capture;     // latch input beat
    logic    do_load;     // append element / close block
    logic    do_clear;    // empty the store
    logic    key_first;   // read key of block 0
    logic    key_step;    // read key of next block
    logic    elem_first;  // read element 0 of current block
    logic    elem_step;   // read next element
    logic    res_load;    // capture result
    status_t res_code;
    logic    res_found;   // result carries block/position
    logic    out_push;    // move result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    mode_t mode;
    logic  no_blocks;
    logic  full;
    logic  key_hit;
    logic  key_last;
    logic  elem_hit;
    logic  elem_last;
    logic  out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/block_index_search_unit.sv -----
// ---------------------------------------------------------------------------
// block_index_search_unit - indexed sequential search over signed values
// Top level: controller plus datapath, stream in, stream out.
// ---------------------------------------------------------------------------
// Each input beat gives exactly one result beat. A load (tuser 0) appends
// tdata to the open block; tlast closes it. Every closed block keeps as key
// its largest element. A search (tuser 1) walks the keys of the closed
// blocks in order until one is >= the value, then scans that block for the
// first equal element and answers found with block and position, or not
// found. Elements of a block still open are never searched. Clear (tuser 2)
// empties the store; tuser 3 answers not found and changes nothing. A load
// into a store with all blocks closed, or into a full open block, drops the
// element and answers full (tlast still closes a non-empty open block).
// Timing: one item at a time. A search reads the keys of the closed blocks
// (up to MAX_BLOCKS, none when no block is closed) at one key-memory read
// per cycle in the walk, then the elements of the chosen block (up to
// MAX_BLOCK_LEN) at one element-memory read per cycle in the scan. A
// waiting result sits in the output register while the next item is taken;
// the emit step holds while an earlier result still waits there unaccepted.
// No clearing pass after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module block_index_search_unit
  import bis_pkg::*;
#(
  parameter  int MAX_BLOCKS    = 8,
  parameter  int MAX_BLOCK_LEN = 16,
  parameter  int VALUE_WIDTH   = 32,
  localparam int IN_W          = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_W-1:0]       in_tdata,   // value[VALUE_WIDTH-1:0], zero pad
  input  wire logic [MODE_W-1:0]     in_tuser,   // mode[1:0]
  input  wire logic                  in_tlast,   // end_of_block
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // block_index[2:0], position[6:3], pad
  output logic [STATUS_W-1:0]        out_tuser   // status[1:0]
);

  `include "block_index_search_unit_defines.svh"

  cmd_t cmd;
  sts_t sts;

  bis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bis_datapath #(
    .MAX_BLOCKS    (MAX_BLOCKS),
    .MAX_BLOCK_LEN (MAX_BLOCK_LEN),
    .VALUE_WIDTH   (VALUE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // one item in flight: ready drops right after an accepted beat
  `BIS_ASSERT_NXT(a_one_in_flight, clk, rst_n, (in_tvalid && in_tready), !in_tready,
                  "second beat accepted while busy")
  // a result is only captured while the input side is closed
  `BIS_ASSERT_IMP(a_result_while_busy, clk, rst_n, cmd.res_load, !in_tready,
                  "result formed while idle")

endmodule

`default_nettype wire

// ----- rtl/bis_ctrl.sv -----
// ---------------------------------------------------------------------------
// bis_ctrl - block index search controller
// Sequences load, clear and the two-phase search (key walk, block scan).
// ---------------------------------------------------------------------------
`default_nettype none

module bis_ctrl
  import bis_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (sts.mode == MODE_SEARCH && !sts.no_blocks) state_nxt = S_KEY;
        else state_nxt = S_EMIT;
      end
      S_KEY: begin
        if (sts.key_hit) state_nxt = S_ELEM;
        else if (sts.key_last) state_nxt = S_EMIT;
      end
      S_ELEM: begin
        if (sts.elem_hit || sts.elem_last) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.res_code = ST_MISS;
    in_tready    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      S_DECODE: begin
        cmd.res_load = 1'b1;
        case (sts.mode)
          MODE_LOAD: begin
            cmd.do_load  = 1'b1;
            cmd.res_code = sts.full ? ST_FULL : ST_DONE;
          end
          MODE_SEARCH: begin
            cmd.key_first = !sts.no_blocks;
            cmd.res_load  = sts.no_blocks;
          end
          MODE_CLEAR: begin
            cmd.do_clear = 1'b1;
            cmd.res_code = ST_DONE;
          end
          default: cmd.res_code = ST_MISS;
        endcase
      end
      S_KEY: begin
        if (sts.key_hit) begin
          cmd.elem_first = 1'b1;
        end else if (sts.key_last) begin
          cmd.res_load = 1'b1;
        end else begin
          cmd.key_step = 1'b1;
        end
      end
      S_ELEM: begin
        if (sts.elem_hit) begin
          cmd.res_load  = 1'b1;
          cmd.res_code  = ST_FOUND;
          cmd.res_found = 1'b1;
        end else if (sts.elem_last) begin
          cmd.res_load = 1'b1;
        end else begin
          cmd.elem_step = 1'b1;
        end
      end
      S_EMIT: begin
        cmd.out_push = sts.out_free;
      end
      default: in_tready = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/bis_datapath.sv -----
// ---------------------------------------------------------------------------
// bis_datapath - block index search datapath
// Element, key and length memories, fill counters, scan pointers, result
// and output registers.
// ---------------------------------------------------------------------------
`default_nettype none

module bis_datapath
  import bis_pkg::*;
#(
  parameter  int MAX_BLOCKS    = 8,
  parameter  int MAX_BLOCK_LEN = 16,
  parameter  int VALUE_WIDTH   = 32,
  localparam int IN_W          = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [IN_W-1:0]       in_tdata,
  input  wire logic [MODE_W-1:0]     in_tuser,
  input  wire logic                  in_tlast,
  input  wire cmd_t                  cmd,
  output sts_t                       sts,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [STATUS_W-1:0]        out_tuser
);

  `include "block_index_search_unit_defines.svh"

  localparam int DEPTH  = MAX_BLOCKS * MAX_BLOCK_LEN;
  localparam int BLK_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int POS_W  = (MAX_BLOCK_LEN > 1) ? $clog2(MAX_BLOCK_LEN) : 1;
  localparam int LEN_W  = $clog2(MAX_BLOCK_LEN + 1);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // storage
  logic signed [VALUE_WIDTH-1:0] elem_mem [DEPTH];
  logic signed [VALUE_WIDTH-1:0] key_mem  [MAX_BLOCKS];
  logic        [LEN_W-1:0]       len_mem  [MAX_BLOCKS];

  logic signed [VALUE_WIDTH-1:0] elem_q, key_q;
  logic        [LEN_W-1:0]       len_q;

  // latched item
  mode_t                         mode_r;
  logic signed [VALUE_WIDTH-1:0] val_r;
  logic                          eob_r;

  logic [CNT_W-1:0]              count_r;
  logic [LEN_W-1:0]              fill_r;
  logic signed [VALUE_WIDTH-1:0] max_r;   // running max of the open block

  logic [BLK_W-1:0]              b_r;
  logic [POS_W-1:0]              j_r;

  status_t                       res_status_r;
  logic [BLK_OUT_W-1:0]          res_blk_r;
  logic [POS_OUT_W-1:0]          res_pos_r;

  logic                          out_valid_r;
  logic [OUT_DATA_W-1:0]         out_data_r;
  logic [STATUS_W-1:0]           out_user_r;

  logic                          full;
  logic                          close_blk;
  logic [LEN_W-1:0]              fill_after;
  logic signed [VALUE_WIDTH-1:0] key_w;
  logic [BLK_W-1:0]              wr_blk;
  logic [ADDR_W-1:0]             wr_addr;
  logic [BLK_W-1:0]              key_rd_addr;
  logic [POS_W-1:0]              j_rd;
  logic [ADDR_W-1:0]             elem_rd_addr;

  always_comb begin
    full       = (count_r >= CNT_W'(MAX_BLOCKS)) || (fill_r >= LEN_W'(MAX_BLOCK_LEN));
    key_w      = (fill_r == '0 || val_r > max_r) ? val_r : max_r;
    fill_after = full ? fill_r : fill_r + LEN_W'(1);
    close_blk  = eob_r && (count_r < CNT_W'(MAX_BLOCKS)) && (fill_after != '0);
    wr_blk     = count_r[BLK_W-1:0];
    wr_addr    = ADDR_W'(wr_blk) * ADDR_W'(MAX_BLOCK_LEN) + ADDR_W'(fill_r[POS_W-1:0]);

    key_rd_addr  = cmd.key_first ? '0 : b_r + BLK_W'(1);
    j_rd         = cmd.elem_first ? '0 : j_r + POS_W'(1);
    elem_rd_addr = ADDR_W'(b_r) * ADDR_W'(MAX_BLOCK_LEN) + ADDR_W'(j_rd);
  end

  // element memory
  always_ff @(posedge clk) begin
    if (cmd.do_load && !full) begin
      elem_mem[wr_addr] <= val_r;
    end
    elem_q <= elem_mem[elem_rd_addr];
  end

  // key memory: entry of the open block tracks its running max
  always_ff @(posedge clk) begin
    if (cmd.do_load && !full) begin
      key_mem[wr_blk] <= key_w;
    end
    key_q <= key_mem[key_rd_addr];
  end

  // length memory, written when a block closes
  always_ff @(posedge clk) begin
    if (cmd.do_load && close_blk) begin
      len_mem[wr_blk] <= fill_after;
    end
    len_q <= len_mem[b_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      fill_r  <= '0;
    end else if (cmd.do_clear) begin
      count_r <= '0;
      fill_r  <= '0;
    end else if (cmd.do_load) begin
      count_r <= close_blk ? count_r + CNT_W'(1) : count_r;
      fill_r  <= close_blk ? '0 : fill_after;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= mode_t'(in_tuser);
      val_r  <= $signed(in_tdata[VALUE_WIDTH-1:0]);
      eob_r  <= in_tlast;
    end
    if (cmd.do_load && !full) begin
      max_r <= key_w;
    end
    if (cmd.key_first || cmd.key_step) begin
      b_r <= key_rd_addr;
    end
    if (cmd.elem_first || cmd.elem_step) begin
      j_r <= j_rd;
    end
    if (cmd.res_load) begin
      res_status_r <= cmd.res_code;
      res_blk_r    <= cmd.res_found ? BLK_OUT_W'(b_r) : '0;
      res_pos_r    <= cmd.res_found ? POS_OUT_W'(j_r) : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_push) begin
      out_data_r <= OUT_DATA_W'({res_pos_r, res_blk_r});
      out_user_r <= res_status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    sts.mode      = mode_r;
    sts.no_blocks = (count_r == '0);
    sts.full      = full;
    sts.key_hit   = (val_r <= key_q);
    sts.key_last  = (CNT_W'(b_r) + CNT_W'(1) == count_r);
    sts.elem_hit  = (elem_q == val_r);
    sts.elem_last = (LEN_W'(j_r) + LEN_W'(1) == len_q);
    sts.out_free  = !out_valid_r || out_tready;
  end

  `BIS_ASSERT_IMP(a_key_in_range, clk, rst_n, cmd.key_step,
                  (CNT_W'(b_r) + CNT_W'(1) < count_r), "key walk past last closed block")
  `BIS_ASSERT_IMP(a_elem_in_range, clk, rst_n, cmd.elem_step,
                  (LEN_W'(j_r) + LEN_W'(1) < len_q), "element scan past block length")
  `BIS_ASSERT_IMP(a_full_store_empty_fill, clk, rst_n, (count_r == CNT_W'(MAX_BLOCKS)),
                  (fill_r == '0), "open block filled with all blocks closed")
  `BIS_ASSERT_IMP(a_push_free, clk, rst_n, cmd.out_push,
                  (!out_valid_r || out_tready), "result overwrites waiting beat")

endmodule

`default_nettype wire
